@@ hdl/bmd_pkg.sv @@
`default_nettype none

package bmd_pkg;

  // mesh geometry
  localparam int CELLS_X         = 64;
  localparam int CELLS_Y         = 64;
  localparam int COORD_FRAC_BITS = 20;
  localparam int SUM_WIDTH       = 48;

  localparam int NODES_X    = CELLS_X + 1;
  localparam int NODE_COUNT = (CELLS_X + 1) * (CELLS_Y + 1);
  localparam int ADDR_W     = $clog2(NODE_COUNT);
  localparam int AREA       = CELLS_X * CELLS_Y;

  // port field widths
  localparam int POS_W   = 21;
  localparam int INDEX_W = 13;
  localparam int VALUE_W = 48;

  // fixed point: offsets span 0..2^F inclusive
  localparam int OFF_W = COORD_FRAC_BITS + 1;
  localparam int CX_W  = $clog2(CELLS_X);
  localparam int CY_W  = $clog2(CELLS_Y);
  localparam int SCX_W = OFF_W + $clog2(CELLS_X + 1);
  localparam int SCY_W = OFF_W + $clog2(CELLS_Y + 1);
  localparam int PROD_W = 2 * OFF_W;
  localparam int ACC_W  = ((SUM_WIDTH > PROD_W) ? SUM_WIDTH : PROD_W) + 1;

  localparam logic [OFF_W-1:0]     ONE_FIX = OFF_W'(1) << COORD_FRAC_BITS;
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

  // corner sequence: bit 0 steps in x, bit 1 steps in y
  localparam logic [1:0] CORNER_LAST = 2'b11;

  typedef enum logic {
    ACT_DEPOSIT = 1'b0,
    ACT_READ    = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEPOSIT,
    ST_FETCH,
    ST_RETURN
  } state_t;

endpackage

`default_nettype wire

@@ hdl/bmd_ram.sv @@
`default_nettype none

module bmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hdl/bilinear_mesh_deposit.sv @@
`default_nettype none

// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+------------------------------------
// in       | in        | in_valid, in_stall   | action, x_pos, y_pos, node_index
// out      | out       | out_valid, out_stall | node_value, saturated
//
// deposit: each point is located in its cell as it is taken, then its four corner
//   read-modify-writes stream through the mesh memory (one read, one write port)
// read: the node is fetched from the mesh memory and its result registered; a read
//   waits while a previous result is still held in the output register
// reset: a clearing pass writes zero to all 4225 nodes, one per cycle, with
//   in_stall high throughout
// out_stall only holds the output register; deposits keep flowing meanwhile

module bilinear_mesh_deposit
  import bmd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic               action,
  input  wire logic [POS_W-1:0]   x_pos,
  input  wire logic [POS_W-1:0]   y_pos,
  input  wire logic [INDEX_W-1:0] node_index,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [VALUE_W-1:0] node_value,
  output      logic               saturated
);

  state_t state, state_next;

  // control
  logic [ADDR_W-1:0] clr_addr;
  logic [1:0]        corner;
  logic              wr_valid;
  logic              in_accept;

  // item registers
  logic [CX_W-1:0]    cell_x;
  logic [CY_W-1:0]    cell_y;
  logic [OFF_W-1:0]   off_x;
  logic [OFF_W-1:0]   off_y;
  logic [INDEX_W-1:0] idx_reg;
  logic               idx_ok;

  // write-back stage
  logic [ADDR_W-1:0] wr_addr;
  logic [PROD_W-1:0] wr_weight;

  // memory ports
  logic                 ram_wr_en;
  logic [ADDR_W-1:0]    ram_wr_addr;
  logic [SUM_WIDTH-1:0] ram_wr_data;
  logic [ADDR_W-1:0]    ram_rd_addr;
  logic [SUM_WIDTH-1:0] ram_rd_data;

  // locate, x and y
  logic [OFF_W-1:0] px, py;
  logic [SCX_W-1:0] scaled_x, cx_wide;
  logic [SCY_W-1:0] scaled_y, cy_wide;
  logic [CX_W-1:0]  loc_cell_x;
  logic [CY_W-1:0]  loc_cell_y;
  logic [OFF_W-1:0] loc_off_x, loc_off_y;

  // corner weight and address
  logic [ADDR_W-1:0] base_addr, corner_addr;
  logic [OFF_W-1:0]  wgt_a, wgt_b;
  logic [PROD_W-1:0] product, weight;

  // saturating add
  logic [ACC_W-1:0]     acc;
  logic [SUM_WIDTH-1:0] sat_sum;

  assign in_accept = in_valid && !in_stall;

  // coordinate to cell index and in-cell offset, 1.0 lands in the last cell
  always_comb begin
    px = OFF_W'(x_pos);
    if (px > ONE_FIX) begin
      px = ONE_FIX;
    end
    scaled_x = SCX_W'(px) * SCX_W'(CELLS_X);
    cx_wide  = scaled_x >> COORD_FRAC_BITS;
    if (cx_wide >= SCX_W'(CELLS_X)) begin
      loc_cell_x = CX_W'(CELLS_X - 1);
    end else begin
      loc_cell_x = CX_W'(cx_wide);
    end
    loc_off_x = OFF_W'(scaled_x - (SCX_W'(loc_cell_x) << COORD_FRAC_BITS));

    py = OFF_W'(y_pos);
    if (py > ONE_FIX) begin
      py = ONE_FIX;
    end
    scaled_y = SCY_W'(py) * SCY_W'(CELLS_Y);
    cy_wide  = scaled_y >> COORD_FRAC_BITS;
    if (cy_wide >= SCY_W'(CELLS_Y)) begin
      loc_cell_y = CY_W'(CELLS_Y - 1);
    end else begin
      loc_cell_y = CY_W'(cy_wide);
    end
    loc_off_y = OFF_W'(scaled_y - (SCY_W'(loc_cell_y) << COORD_FRAC_BITS));
  end

  // corner order: lower left, lower right, upper left, upper right
  always_comb begin
    base_addr   = ADDR_W'(cell_y) * ADDR_W'(NODES_X) + ADDR_W'(cell_x);
    corner_addr = base_addr;
    if (corner[0]) begin
      corner_addr = corner_addr + ADDR_W'(1);
    end
    if (corner[1]) begin
      corner_addr = corner_addr + ADDR_W'(NODES_X);
    end
    wgt_a   = corner[0] ? off_x : ONE_FIX - off_x;
    wgt_b   = corner[1] ? off_y : ONE_FIX - off_y;
    product = PROD_W'(wgt_a) * PROD_W'(wgt_b);
    weight  = PROD_W'(product / AREA);
  end

  // read data of the corner fetched last cycle plus its registered weight
  always_comb begin
    acc = ACC_W'(ram_rd_data) + ACC_W'(wr_weight);
    if (acc > ACC_W'(SUM_MAX)) begin
      sat_sum = SUM_MAX;
    end else begin
      sat_sum = SUM_WIDTH'(acc);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(NODE_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (action == ACT_READ) ? ST_FETCH : ST_DEPOSIT;
        end
      end
      ST_DEPOSIT: begin
        if (corner == CORNER_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_FETCH:  state_next = ST_RETURN;
      ST_RETURN: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs: input stall and memory port steering
  always_comb begin
    in_stall    = 1'b1;
    ram_rd_addr = corner_addr;
    ram_wr_en   = wr_valid;
    ram_wr_addr = wr_addr;
    ram_wr_data = sat_sum;
    unique case (state)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr;
        ram_wr_data = '0;
      end
      ST_IDLE: begin
        // a read needs the output register free
        in_stall = (action == ACT_READ) && out_valid;
      end
      ST_FETCH: begin
        ram_rd_addr = ADDR_W'(idx_reg);
      end
      ST_DEPOSIT, ST_RETURN: begin
        in_stall = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      corner    <= '0;
      wr_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      wr_valid <= (state == ST_DEPOSIT);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (in_accept) begin
        corner <= '0;
      end else if (state == ST_DEPOSIT) begin
        corner <= corner + 2'b01;
      end
      if (state == ST_RETURN) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cell_x  <= loc_cell_x;
      cell_y  <= loc_cell_y;
      off_x   <= loc_off_x;
      off_y   <= loc_off_y;
      idx_reg <= node_index;
      idx_ok  <= (32'(node_index) < 32'(NODE_COUNT));
    end
    if (state == ST_DEPOSIT) begin
      wr_addr   <= corner_addr;
      wr_weight <= weight;
    end
    if (state == ST_RETURN) begin
      // out-of-range node reads as zero, never saturated
      node_value <= idx_ok ? VALUE_W'(ram_rd_data) : '0;
      saturated  <= idx_ok && (ram_rd_data == SUM_MAX);
    end
  end

  bmd_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (NODE_COUNT)
  ) u_mesh (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

`default_nettype wire

@@ hdl/bmd_checker.sv @@
`default_nettype none

module bmd_assertions
  import bmd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               action,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [VALUE_W-1:0] node_value,
  input wire logic               saturated
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(node_value) && $stable(saturated))
    else $error("result changed while stalled");

  // reset starts the clearing pass with nothing pending
  a_reset: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("block not quiet after reset");

  // a read transaction raises its result only after the fetch and return states
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == ACT_READ |=> !out_valid ##1 !out_valid ##1 out_valid)
    else $error("read result timing wrong");

  // a deposit taken while no result is held does not produce a result
  a_deposit_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == ACT_DEPOSIT && !out_valid |=> !out_valid)
    else $error("deposit produced a result");

  // saturation flag matches the ceiling value
  a_sat_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> saturated == (&node_value))
    else $error("saturation flag inconsistent");

endmodule

bind bilinear_mesh_deposit bmd_assertions u_bmd_assertions (.*);

`default_nettype wire

@@ dv/bmd_checker.sv @@
`default_nettype none

// watches both channels, keeps its own copy of the mesh and compares every
// returned node read with the value predicted at the time the read was taken
module bmd_checker
  import bmd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic               action,
  input  wire logic [POS_W-1:0]   x_pos,
  input  wire logic [POS_W-1:0]   y_pos,
  input  wire logic [INDEX_W-1:0] node_index,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [VALUE_W-1:0] node_value,
  input  wire logic               saturated,
  output int unsigned             fail_count,
  output int unsigned             reads_pending
);

  localparam int SCALED_W = OFF_W + 11;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               sat;
  } node_read_t;

  logic [SUM_WIDTH-1:0] charge_mesh [NODE_COUNT];
  node_read_t           node_reads_due [$];
  int unsigned          mismatches = 0;
  int unsigned          reads_due = 0;

  assign fail_count    = mismatches;
  assign reads_pending = reads_due;

  // cell index and in-cell offset of one coordinate, above 1.0 clamps to 1.0
  function automatic void locate_cell(input logic [POS_W-1:0] pos, input int cells,
                                      output int cell_idx, output logic [OFF_W-1:0] off);
    logic [OFF_W-1:0]    p;
    logic [SCALED_W-1:0] scaled;
    p        = (pos > ONE_FIX) ? ONE_FIX : pos;
    scaled   = SCALED_W'(p) * SCALED_W'(cells);
    cell_idx = int'(scaled >> COORD_FRAC_BITS);
    if (cell_idx >= cells) cell_idx = cells - 1;
    off = OFF_W'(scaled - (SCALED_W'(cell_idx) << COORD_FRAC_BITS));
  endfunction

  function automatic logic [PROD_W-1:0] area_weight(input logic [OFF_W-1:0] a, b);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(a) * PROD_W'(b);
    return prod / PROD_W'(AREA);
  endfunction

  function automatic void add_weight(input int node, input logic [PROD_W-1:0] w);
    logic [ACC_W-1:0] sum;
    sum = ACC_W'(charge_mesh[node]) + ACC_W'(w);
    charge_mesh[node] = (sum > ACC_W'(SUM_MAX)) ? SUM_MAX : sum[SUM_WIDTH-1:0];
  endfunction

  function automatic void deposit_point(input logic [POS_W-1:0] x, y);
    int               ci, cj, base;
    logic [OFF_W-1:0] tx, ty, sx, sy;
    locate_cell(x, CELLS_X, ci, tx);
    locate_cell(y, CELLS_Y, cj, ty);
    sx   = ONE_FIX - tx;
    sy   = ONE_FIX - ty;
    base = cj * NODES_X + ci;
    add_weight(base, area_weight(sx, sy));
    add_weight(base + 1, area_weight(tx, sy));
    add_weight(base + NODES_X, area_weight(sx, ty));
    add_weight(base + NODES_X + 1, area_weight(tx, ty));
  endfunction

  // out of range nodes read back as zero, not saturated
  function automatic node_read_t read_node(input logic [INDEX_W-1:0] idx);
    node_read_t r;
    r = '0;
    if (idx < NODE_COUNT) begin
      r.value = charge_mesh[idx][VALUE_W-1:0];
      r.sat   = (charge_mesh[idx] == SUM_MAX);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    node_read_t want;
    if (rst) begin
      foreach (charge_mesh[k]) charge_mesh[k] = '0;
      node_reads_due.delete();
    end else begin
      // results first: a read taken at this edge cannot return at this edge
      if (out_valid && !out_stall) begin
        if (node_reads_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none actual node_value %0h saturated %0b",
                   $time, node_value, saturated);
        end else begin
          want = node_reads_due.pop_front();
          if (node_value !== want.value) begin
            mismatches++;
            $display("%0t: node_value expected %0h actual %0h", $time, want.value, node_value);
          end
          if (saturated !== want.sat) begin
            mismatches++;
            $display("%0t: saturated expected %0b actual %0b", $time, want.sat, saturated);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (action == ACT_DEPOSIT) deposit_point(x_pos, y_pos);
        else node_reads_due.push_back(read_node(node_index));
      end
    end
    reads_due = node_reads_due.size();
  end

endmodule

`default_nettype wire

@@ dv/tb_bilinear_mesh_deposit.sv @@
`default_nettype none

// stimulus and verdict for the cloud-in-cell deposit block; prediction and
// comparison live in bmd_checker beside the dut
module tb_bilinear_mesh_deposit;
  import bmd_pkg::*;

  localparam int RANDOM_ITEMS   = 1250;
  localparam int STALL_MAX      = 12;
  // the clearing pass after reset holds in_stall on its own while it zeroes all 4225 nodes
  localparam int WATCHDOG_LIMIT = 20000;
  // settling covers a deposit's four corner writes and a read's fetch and return
  localparam int SETTLE_CYCLES  = 20;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               action     = ACT_DEPOSIT;
  logic [POS_W-1:0]   x_pos      = '0;
  logic [POS_W-1:0]   y_pos      = '0;
  logic [INDEX_W-1:0] node_index = '0;
  logic               out_stall  = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [VALUE_W-1:0] node_value;
  logic               saturated;

  int unsigned fail_count;
  int unsigned reads_pending;
  int unsigned idle_cycles = 0;

  // calm phases: no gaps on that side at all
  bit in_calm  = 1'b0;
  bit out_calm = 1'b0;

  always #5 clk = ~clk;

  bilinear_mesh_deposit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .node_index (node_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .node_value (node_value),
    .saturated  (saturated)
  );

  bmd_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .x_pos         (x_pos),
    .y_pos         (y_pos),
    .node_index    (node_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .node_value    (node_value),
    .saturated     (saturated),
    .fail_count    (fail_count),
    .reads_pending (reads_pending)
  );

  function automatic logic [INDEX_W-1:0] node_at(input int col, input int row);
    return INDEX_W'(row * NODES_X + col);
  endfunction

  // coordinate mix: whole field range (clamps above 1.0), exactly 1.0, a small
  // corner region where sums stack up, cell boundaries, and plain [0,1]
  function automatic logic [POS_W-1:0] rand_pos(input int cells);
    case ($urandom_range(0, 9))
      0:       return POS_W'($urandom_range(0, (1 << POS_W) - 1));
      1:       return ONE_FIX;
      2, 3:    return POS_W'($urandom_range(0, 1 << 16));
      4:       return POS_W'(($urandom_range(0, cells) << COORD_FRAC_BITS) / cells);
      default: return POS_W'($urandom_range(0, 1 << COORD_FRAC_BITS));
    endcase
  endfunction

  // reads lean toward the corner region, with some past the last node
  function automatic logic [INDEX_W-1:0] rand_node();
    case ($urandom_range(0, 9))
      0:       return INDEX_W'($urandom_range(NODE_COUNT, (1 << INDEX_W) - 1));
      1, 2, 3: return node_at($urandom_range(0, 5), $urandom_range(0, 5));
      default: return INDEX_W'($urandom_range(0, NODE_COUNT - 1));
    endcase
  endfunction

  // one input transaction: optional gap, then hold until the dut takes it;
  // valid stays high straight into the next transaction when the gap is zero
  task automatic send_item(input action_t act, input logic [POS_W-1:0] x, y,
                           input logic [INDEX_W-1:0] idx);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    x_pos      <= x;
    y_pos      <= y;
    node_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // unused payload fields carry random junk
  task automatic deposit(input logic [POS_W-1:0] x, y);
    send_item(ACT_DEPOSIT, x, y, INDEX_W'($urandom));
  endtask

  task automatic read_back(input logic [INDEX_W-1:0] idx);
    send_item(ACT_READ, POS_W'($urandom), POS_W'($urandom), idx);
  endtask

  // stop sending until every outstanding read has come back
  task automatic wait_for_reads();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reads_pending != 0) @(posedge clk);
  endtask

  // receiver: draws a stall length per transaction, stalls also fall while idle
  initial begin : result_sink
    int hold;
    forever begin
      hold = out_calm ? 0 : $urandom_range(0, STALL_MAX);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("bilinear_mesh_deposit: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: corners, 1.0 and clamped coordinates, quarter splits
    deposit('0, '0);                                   // all weight into node 0
    deposit(ONE_FIX, ONE_FIX);                         // last cell, full offset
    deposit('1, '0);                                   // x above 1.0 clamps
    deposit('0, '1);                                   // y above 1.0 clamps
    deposit(POS_W'(1 << 13), POS_W'(1 << 13));         // mid cell, four equal shares
    deposit(POS_W'(1 << 14), POS_W'(3 << 14));         // exactly on a cell boundary
    deposit(POS_W'(20'hABCDE), POS_W'(20'h12345));
    deposit(ONE_FIX - 1, ONE_FIX - 1);                 // just under 1.0
    deposit(ONE_FIX + 1, ONE_FIX);                     // one lsb above 1.0
    read_back(node_at(0, 0));
    read_back(node_at(1, 0));
    read_back(node_at(0, 1));
    read_back(node_at(1, 1));
    read_back(node_at(CELLS_X, 0));
    read_back(node_at(0, CELLS_Y));
    read_back(node_at(CELLS_X, CELLS_Y));
    read_back(node_at(CELLS_X - 1, CELLS_Y - 1));
    read_back(node_at(1, 3));
    read_back(node_at(2, 4));
    read_back(INDEX_W'(NODE_COUNT));                   // first index past the mesh
    read_back('1);
    read_back(node_at(5, 5));                          // never touched

    // pause until the directed reads are all back
    wait_for_reads();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // reshuffle the idling phases now and then
      if (n % 100 == 0) begin
        in_calm  = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_ITEMS / 2) wait_for_reads();
      if ($urandom_range(0, 4) < 3) deposit(rand_pos(CELLS_X), rand_pos(CELLS_Y));
      else read_back(rand_node());
    end

    wait_for_reads();
    // let any deposit still in flight finish before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("bilinear_mesh_deposit: match");
    else $display("bilinear_mesh_deposit: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
